// File: rtl/json_string_unescape_utf8_assert.svh
// Assertion macros shared by the JSON string unescaper RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define JSU_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define JSU_CHECK_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by the decoder, the job queue, the serializer and the top level.
package jsu_pkg;

    // Result kinds carried in the output tuser.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Default depth of the queue between the decoder and the serializer.
    localparam int JSU_QUEUE_DEPTH = 4;

    // One decoded job: an optional U+FFFD prefix followed by an optional tail.
    // A data tail of length one is a raw byte; longer tails are UTF-8 of cp.
    typedef struct packed {
        logic        fffd;
        logic [1:0]  kind;
        logic [2:0]  len;
        logic [20:0] cp;
    } t_job;

endpackage

// File: rtl/jsu_front.sv
// Decoder front end: escape and \u state machine, one input word per cycle while i_accept is high.
// Produces one job per word that yields output. Depends on jsu_pkg.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_ended,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_ESC      = 3'd1;
    localparam logic [2:0] MODE_HEX1     = 3'd2;
    localparam logic [2:0] MODE_HIGH     = 3'd3;
    localparam logic [2:0] MODE_HIGH_ESC = 3'd4;
    localparam logic [2:0] MODE_HEX2     = 3'd5;

    localparam logic [20:0] CP_REPL = 21'h00FFFD;

    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_count, n_count;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_held, n_held;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Number of UTF-8 bytes for a code point.
    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] r;
        if (cp < 21'h80) begin
            r = 3'd1;
        end else if (cp < 21'h800) begin
            r = 3'd2;
        end else if (cp < 21'h10000) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    logic [4:0]  dig;
    logic        d_ok;
    logic [15:0] v16;
    logic        last_dig;
    logic [20:0] pair_cp;
    logic        do_plain, do_letter, do_single, do_error, do_pair, do_fffd;
    logic        tail_cp;
    logic [20:0] cp_sel;
    t_job        job;

    assign dig      = hex_val(i_byte);
    assign d_ok     = dig[4] && !i_ended;
    assign v16      = {r_acc[11:0], dig[3:0]};
    assign last_dig = (r_count == 2'd3);
    assign pair_cp  = {(11'(r_held) + 11'd64), v16[9:0]};

    // Next state and job for the word on the input.
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_acc     = r_acc;
        n_held    = r_held;
        do_plain  = 1'b0;
        do_letter = 1'b0;
        do_single = 1'b0;
        do_error  = 1'b0;
        do_pair   = 1'b0;
        do_fffd   = 1'b0;
        tail_cp   = 1'b0;
        cp_sel    = 21'd0;
        job       = '0;

        unique case (r_mode)
            MODE_ESC: begin
                if (i_ended) begin
                    do_error = 1'b1;
                end else begin
                    do_letter = 1'b1;
                end
            end
            MODE_HEX1: begin
                if (!d_ok) begin
                    do_error = 1'b1;
                end else if (last_dig) begin
                    do_single = 1'b1;
                end else begin
                    n_count = r_count + 2'd1;
                    n_acc   = v16;
                end
            end
            MODE_HIGH: begin
                if (i_ended) begin
                    do_fffd  = 1'b1;
                    do_error = 1'b1;
                end else if (i_byte == 8'h5C) begin
                    n_mode = MODE_HIGH_ESC;
                end else begin
                    do_fffd  = 1'b1;
                    do_plain = 1'b1;
                end
            end
            MODE_HIGH_ESC: begin
                if (i_ended) begin
                    do_fffd  = 1'b1;
                    do_error = 1'b1;
                end else if (i_byte == 8'h75) begin
                    n_mode  = MODE_HEX2;
                    n_count = 2'd0;
                    n_acc   = 16'd0;
                end else begin
                    do_fffd   = 1'b1;
                    do_letter = 1'b1;
                end
            end
            MODE_HEX2: begin
                if (!d_ok) begin
                    do_fffd  = 1'b1;
                    do_error = 1'b1;
                end else if (last_dig) begin
                    if (v16[15:10] == 6'b110111) begin
                        do_pair = 1'b1;
                    end else begin
                        do_fffd   = 1'b1;
                        do_single = 1'b1;
                    end
                end else begin
                    n_count = r_count + 2'd1;
                    n_acc   = v16;
                end
            end
            default: begin
                // Plain copying; unused codes behave the same way.
                if (i_ended) begin
                    do_error = 1'b1;
                end else begin
                    do_plain = 1'b1;
                end
            end
        endcase

        // Finished steps clear state and return to plain mode; handlers below may override.
        if (do_error || do_plain || do_letter || do_single || do_pair) begin
            n_mode  = MODE_PLAIN;
            n_count = 2'd0;
            n_acc   = 16'd0;
            n_held  = 10'd0;
        end

        job.fffd = do_fffd;

        if (do_error) begin
            job.kind = KIND_ERROR;
            job.len  = 3'd1;
        end

        if (do_plain) begin
            if (i_byte == 8'h22) begin
                job.kind = KIND_CLOSE;
                job.len  = 3'd1;
            end else if (i_byte == 8'h5C) begin
                n_mode = MODE_ESC;
            end else begin
                job.kind = KIND_DATA;
                job.len  = 3'd1;
                job.cp   = {13'd0, i_byte};
            end
        end

        if (do_letter) begin
            job.kind = KIND_DATA;
            job.len  = 3'd1;
            unique case (i_byte)
                8'h22:   job.cp = 21'h22;
                8'h5C:   job.cp = 21'h5C;
                8'h2F:   job.cp = 21'h2F;
                8'h62:   job.cp = 21'h08;
                8'h66:   job.cp = 21'h0C;
                8'h6E:   job.cp = 21'h0A;
                8'h72:   job.cp = 21'h0D;
                8'h74:   job.cp = 21'h09;
                8'h75: begin
                    job.len = 3'd0;
                    n_mode  = MODE_HEX1;
                end
                default: job.kind = KIND_ERROR;
            endcase
        end

        if (do_single) begin
            if (v16[15:10] == 6'b110110) begin
                n_held = v16[9:0];
                n_mode = MODE_HIGH;
            end else if (v16[15:10] == 6'b110111) begin
                tail_cp = 1'b1;
                cp_sel  = CP_REPL;
            end else begin
                tail_cp = 1'b1;
                cp_sel  = {5'd0, v16};
            end
        end

        if (do_pair) begin
            tail_cp = 1'b1;
            cp_sel  = pair_cp;
        end

        if (tail_cp) begin
            job.kind = KIND_DATA;
            job.len  = cp_len(cp_sel);
            job.cp   = cp_sel;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.fffd || (job.len != 3'd0));

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_count <= 2'd0;
            r_acc   <= 16'd0;
            r_held  <= 10'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_held  <= n_held;
        end
    end

endmodule

// File: rtl/jsu_queue.sv
// Small job queue between the decoder and the serializer.
// Register array with read and write pointers. Depends on jsu_pkg.
`include "json_string_unescape_utf8_assert.svh"

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `JSU_CHECK(a_no_overflow, i_clk, i_rst_n, !(i_push && r_count == CNT_FULL), "queue overflow")
    `JSU_CHECK(a_no_underflow, i_clk, i_rst_n, !(i_pop && r_count == '0), "queue underflow")
    `JSU_CHECK(a_count_range, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count out of range")

endmodule

// File: rtl/jsu_back.sv
// Serializer back end: expands queued jobs into result words, one per cycle while the output side takes them.
// Holds the output register of the result stream. Depends on jsu_pkg.
`include "json_string_unescape_utf8_assert.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic [1:0] o_kind,
    output logic       o_last,
    input  logic       i_ready
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic       r_last;

    logic [2:0] total;
    logic [2:0] j;
    logic       in_prefix;
    logic       is_last;
    logic       load;
    logic [7:0] c_byte;
    logic [1:0] c_kind;

    assign total     = i_job.len + (i_job.fffd ? 3'd3 : 3'd0);
    assign in_prefix = i_job.fffd && (r_idx < 3'd3);
    assign j         = i_job.fffd ? (r_idx - 3'd3) : r_idx;
    assign is_last   = (r_idx == (total - 3'd1));
    assign load      = i_valid && (!r_valid || i_ready);
    assign o_pop     = load && is_last;

    // Byte and kind of the current position within the job.
    always_comb begin
        c_byte = 8'd0;
        c_kind = KIND_DATA;
        if (in_prefix) begin
            unique case (r_idx[1:0])
                2'd0:    c_byte = 8'hEF;
                2'd1:    c_byte = 8'hBF;
                default: c_byte = 8'hBD;
            endcase
        end else if (i_job.kind != KIND_DATA) begin
            c_kind = i_job.kind;
        end else begin
            unique case (i_job.len)
                3'd2: begin
                    c_byte = (j == 3'd0) ? {3'b110, i_job.cp[10:6]}
                                         : {2'b10, i_job.cp[5:0]};
                end
                3'd3: begin
                    unique case (j)
                        3'd0:    c_byte = {4'b1110, i_job.cp[15:12]};
                        3'd1:    c_byte = {2'b10, i_job.cp[11:6]};
                        default: c_byte = {2'b10, i_job.cp[5:0]};
                    endcase
                end
                3'd4: begin
                    unique case (j)
                        3'd0:    c_byte = {5'b11110, i_job.cp[20:18]};
                        3'd1:    c_byte = {2'b10, i_job.cp[17:12]};
                        3'd2:    c_byte = {2'b10, i_job.cp[11:6]};
                        default: c_byte = {2'b10, i_job.cp[5:0]};
                    endcase
                end
                default: c_byte = i_job.cp[7:0];
            endcase
        end
    end

    // Position counter within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (load) begin
            r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= c_byte;
            r_kind <= c_kind;
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    `JSU_CHECK(a_idx_range, i_clk, i_rst_n, r_idx < 3'd6, "job position out of range")
    `JSU_CHECK(a_end_is_last, i_clk, i_rst_n, !(r_valid && r_kind != KIND_DATA) || r_last, "close or error word not marked last")
    `JSU_CHECK_NEXT(a_idx_restart, i_clk, i_rst_n, o_pop, r_idx == 3'd0, "position not cleared after job end")

endmodule

// File: rtl/json_string_unescape_utf8.sv
// JSON string body unescaper to UTF-8. Accepts one input word per cycle while the queue has room.
// An accepted input passes through the job queue and then the output register before its
// first result word is on the master side, when no earlier job is queued and the master side
// is taking words. Throughput: one result word per cycle while the master side takes them;
// the job queue (QUEUE_DEPTH entries) decouples the decoder while the serializer expands a job.
// Reset: synchronous active-low i_rst_n returns the decoder to plain copying and empties the queue.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] text_ended
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);

    logic accept;
    logic push;
    t_job front_job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic pop;

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    // Front end: escape decoding.
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_ended  (s_axis_tuser),
        .o_push   (push),
        .o_job    (front_job)
    );

    // Job queue between the two halves.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // Back end: UTF-8 serialization into the output register.
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_byte  (m_axis_tdata),
        .o_kind  (m_axis_tuser),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );

endmodule
